/* src/hrbt_pkg.sv */
// Shared codes, byte constants and types for the HTTP request byte tagger.
package hrbt_pkg;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_COL = 8'h3A;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  localparam int RoleW = 3;

  localparam logic [RoleW-1:0] ROLE_METHOD  = 3'd0;
  localparam logic [RoleW-1:0] ROLE_URL     = 3'd1;
  localparam logic [RoleW-1:0] ROLE_VERSION = 3'd2;
  localparam logic [RoleW-1:0] ROLE_HNAME   = 3'd3;
  localparam logic [RoleW-1:0] ROLE_HVALUE  = 3'd4;
  localparam logic [RoleW-1:0] ROLE_BNAME   = 3'd5;
  localparam logic [RoleW-1:0] ROLE_BVALUE  = 3'd6;
  localparam logic [RoleW-1:0] ROLE_SEP     = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_item_t;

  typedef struct packed {
    logic [RoleW-1:0] role;
    logic             field_start;
  } tag_t;

endpackage

/* src/hrbt_if.sv */
// Valid/ready stream interfaces for request bytes and tagged bytes.
interface hrbt_in_if
  import hrbt_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_request;

  modport source(output valid, data_byte, new_request, input ready);
  modport sink(input valid, data_byte, new_request, output ready);
endinterface

interface hrbt_out_if
  import hrbt_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [RoleW-1:0] role;
  logic [7:0]       byte_out;
  logic             field_start;

  modport source(output valid, role, byte_out, field_start, input ready);
  modport sink(input valid, role, byte_out, field_start, output ready);
endinterface

/* src/hrbt_phase.sv */
// Parse phase machine: tags one byte per step and advances the phase.
module hrbt_phase
  import hrbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_item_t   item,
  output tag_t       tag
);

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_URL     = 4'd1,
    PH_VERSION = 4'd2,
    PH_RL_LF   = 4'd3,
    PH_HNAME   = 4'd4,
    PH_HVALUE  = 4'd5,
    PH_HLF     = 4'd6,
    PH_BLANKLF = 4'd7,
    PH_BNAME   = 4'd8,
    PH_BVALUE  = 4'd9
  } phase_t;

  phase_t           phase_r, phase_nxt, cur_phase;
  logic             pending_r, pending_nxt, cur_pending;
  logic             sep;
  logic [RoleW-1:0] role;
  logic [7:0]       b;

  assign b = item.data_byte;

  always_comb begin
    // new_request restarts the request line before this byte is handled
    cur_phase   = item.new_request ? PH_METHOD : phase_r;
    cur_pending = item.new_request ? 1'b1 : pending_r;
    phase_nxt   = cur_phase;
    sep         = 1'b1;
    role        = ROLE_SEP;
    unique case (cur_phase)
      PH_URL: begin
        if (b == CH_SP) phase_nxt = PH_VERSION;
        else if (b == CH_CR) phase_nxt = PH_RL_LF;
        else begin sep = 1'b0; role = ROLE_URL; end
      end
      PH_VERSION: begin
        if (b == CH_CR) phase_nxt = PH_RL_LF;
        else begin sep = 1'b0; role = ROLE_VERSION; end
      end
      PH_RL_LF, PH_HLF: phase_nxt = PH_HNAME;
      PH_HNAME: begin
        // CR at the start of a header line is the blank line
        if (b == CH_CR) phase_nxt = cur_pending ? PH_BLANKLF : PH_HLF;
        else if (b == CH_COL) phase_nxt = PH_HVALUE;
        else begin sep = 1'b0; role = ROLE_HNAME; end
      end
      PH_HVALUE: begin
        if (b == CH_CR) phase_nxt = PH_HLF;
        else begin sep = 1'b0; role = ROLE_HVALUE; end
      end
      PH_BLANKLF: phase_nxt = PH_BNAME;
      PH_BNAME: begin
        if (b == CH_AMP) phase_nxt = PH_BNAME;
        else if (b == CH_EQ) phase_nxt = PH_BVALUE;
        else begin sep = 1'b0; role = ROLE_BNAME; end
      end
      PH_BVALUE: begin
        if (b == CH_AMP) phase_nxt = PH_BNAME;
        else begin sep = 1'b0; role = ROLE_BVALUE; end
      end
      default: begin
        // method phase; unreachable codes fall back to it
        if (b == CH_SP) phase_nxt = PH_URL;
        else if (b == CH_CR) phase_nxt = PH_RL_LF;
        else begin sep = 1'b0; role = ROLE_METHOD; phase_nxt = PH_METHOD; end
      end
    endcase
    pending_nxt     = sep;
    tag.role        = role;
    tag.field_start = sep ? 1'b0 : cur_pending;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_METHOD;
      pending_r <= 1'b1;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
    end
  end

  a_restart_method: assert property (@(posedge clk) disable iff (!rst_n)
    item.new_request && b != CH_SP && b != CH_CR
    |-> tag.role == ROLE_METHOD && tag.field_start)
    else $error("restart byte not tagged as method start");

  a_blank_to_body: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.new_request && phase_r == PH_BLANKLF |=> phase_r == PH_BNAME)
    else $error("blank line LF did not enter body");

  a_sep_after_sep_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step && tag.role == ROLE_SEP |=> pending_r)
    else $error("separator did not arm field start");

endmodule

/* src/http_request_byte_tagger_core.sv */
// Top level: input register, phase machine and output register.
//
//  channel  | dir | payload                           | handshake
//  in_chan  | in  | data_byte[7:0], new_request       | valid/ready
//  out_chan | out | role[2:0], byte_out[7:0], field_start | valid/ready
//
// One item per cycle sustained while out_chan is ready; an item is held in the
// input register, then in the output register, before it leaves at out_chan. The rate is
// set by the phase register, updated once per byte.
// Synchronous active-low reset returns the parser to the method phase with
// both stages empty. An output stall holds the output register and backs up
// into the input register; in_chan.ready drops only when both are full.
module http_request_byte_tagger_core
  import hrbt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  hrbt_in_if.sink    in_chan,
  hrbt_out_if.source out_chan
);

  logic     in_vld_r;
  in_item_t in_item_r;
  logic     out_vld_r;
  tag_t     out_tag_r;
  logic [7:0] out_byte_r;
  logic     move;
  tag_t     tag;

  assign move          = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || move;

  hrbt_phase u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (move),
    .item  (in_item_r),
    .tag   (tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_chan.ready) in_vld_r <= in_chan.valid;
      if (move) out_vld_r <= 1'b1;
      else if (out_chan.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.data_byte   <= in_chan.data_byte;
      in_item_r.new_request <= in_chan.new_request;
    end
    if (move) begin
      out_tag_r  <= tag;
      out_byte_r <= in_item_r.data_byte;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.role        = out_tag_r.role;
  assign out_chan.field_start = out_tag_r.field_start;
  assign out_chan.byte_out    = out_byte_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !move |=> in_vld_r && $stable(in_item_r))
    else $error("waiting input item lost or changed");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_vld_r && out_byte_r == $past(in_item_r.data_byte))
    else $error("item did not reach output register");

endmodule
